@@ hw/rtl/shrb_pkg.sv @@
`default_nettype none

package shrb_pkg;

  localparam int RECORDS_A = 100;
  localparam int RECORDS_B = 300;
  localparam int WORDS_A   = 12;
  localparam int WORDS_B   = 1;
  localparam int MAX_WORDS = 64;

  localparam int WORD_W  = 16;
  localparam int SEQ_W   = 32;
  localparam int CMD_W   = 2;
  localparam int WANT_W  = 8;

  localparam int DEPTH_WORDS_A = RECORDS_A * WORDS_A;
  localparam int DEPTH_WORDS_B = RECORDS_B * WORDS_B;

  localparam int SLOT_A_W = $clog2(RECORDS_A);
  localparam int SLOT_B_W = $clog2(RECORDS_B);
  localparam int POS_A_W  = (WORDS_A > 1) ? $clog2(WORDS_A) : 1;
  localparam int POS_B_W  = (WORDS_B > 1) ? $clog2(WORDS_B) : 1;
  localparam int POS_W    = (POS_A_W > POS_B_W) ? POS_A_W : POS_B_W;
  localparam int ADDR_A_W = $clog2(DEPTH_WORDS_A);
  localparam int ADDR_B_W = $clog2(DEPTH_WORDS_B);
  localparam int ADDR_W   = (ADDR_A_W > ADDR_B_W) ? ADDR_A_W : ADDR_B_W;

  localparam int MAX_RECORDS = (RECORDS_A > RECORDS_B) ? RECORDS_A : RECORDS_B;
  localparam int DIFF_W      = $clog2(MAX_RECORDS + 1);
  localparam int IDX_W       = DIFF_W + 1;
  localparam int NREC_W      = $clog2(MAX_WORDS + 1);

  localparam int MAXR_A = MAX_WORDS / WORDS_A;
  localparam int MAXR_B = MAX_WORDS / WORDS_B;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_PEEK  = 2'd1,
    CMD_RESET = 2'd2,
    CMD_NONE  = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SETUP,
    ST_STREAM
  } state_t;

  typedef struct packed {
    logic accept;
    logic check;
    logic setup;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic peek_req;
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/shrb_in_if.sv @@
`default_nettype none

interface shrb_in_if;
  logic                          valid;
  logic                          ready;
  logic [shrb_pkg::CMD_W-1:0]    command;
  logic                          channel;
  logic [shrb_pkg::WORD_W-1:0]   word_in;
  logic [shrb_pkg::SEQ_W-1:0]    start_seq;
  logic [shrb_pkg::WANT_W-1:0]   record_count;

  modport source (
    output valid, command, channel, word_in, start_seq, record_count,
    input  ready
  );

  modport sink (
    input  valid, command, channel, word_in, start_seq, record_count,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/shrb_out_if.sv @@
`default_nettype none

interface shrb_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [shrb_pkg::SEQ_W-1:0]  seq_number;
  logic [shrb_pkg::WORD_W-1:0] word_out;
  logic [shrb_pkg::SEQ_W-1:0]  oldest_seq;
  logic [shrb_pkg::SEQ_W-1:0]  newest_seq;
  logic                        last;

  modport source (
    output valid, status, seq_number, word_out, oldest_seq, newest_seq, last,
    input  ready
  );

  modport sink (
    input  valid, status, seq_number, word_out, oldest_seq, newest_seq, last,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/shrb_ram.sv @@
`default_nettype none

module shrb_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 1200,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/shrb_ctrl.sv @@
`default_nettype none

module shrb_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output shrb_pkg::dp_cmd_t         cmd,
  input  wire shrb_pkg::dp_status_t status
);

  shrb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= shrb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state)
      shrb_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.peek_req) begin
          state_next = shrb_pkg::ST_CHECK;
        end
      end
      shrb_pkg::ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = shrb_pkg::ST_SETUP;
      end
      shrb_pkg::ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = shrb_pkg::ST_STREAM;
      end
      shrb_pkg::ST_STREAM: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready;
        if (out_ready && status.last) begin
          state_next = shrb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = shrb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/shrb_dp.sv @@
`default_nettype none

module shrb_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire shrb_pkg::dp_cmd_t             cmd,
  output shrb_pkg::dp_status_t               status,
  input  wire logic [shrb_pkg::CMD_W-1:0]    command,
  input  wire logic                          channel,
  input  wire logic [shrb_pkg::WORD_W-1:0]   word_in,
  input  wire logic [shrb_pkg::SEQ_W-1:0]    start_seq,
  input  wire logic [shrb_pkg::WANT_W-1:0]   record_count,
  output logic                               res_status,
  output logic [shrb_pkg::SEQ_W-1:0]         seq_number,
  output logic [shrb_pkg::WORD_W-1:0]        word_out,
  output logic [shrb_pkg::SEQ_W-1:0]         oldest_seq,
  output logic [shrb_pkg::SEQ_W-1:0]         newest_seq,
  output logic                               last
);

  localparam int SEQ_W  = shrb_pkg::SEQ_W;
  localparam int WANT_W = shrb_pkg::WANT_W;
  localparam int NREC_W = shrb_pkg::NREC_W;
  localparam int DIFF_W = shrb_pkg::DIFF_W;
  localparam int IDX_W  = shrb_pkg::IDX_W;
  localparam int POS_W  = shrb_pkg::POS_W;
  localparam int ADDR_W = shrb_pkg::ADDR_W;
  localparam int AAW    = shrb_pkg::ADDR_A_W;
  localparam int BAW    = shrb_pkg::ADDR_B_W;

  // channel bookkeeping
  logic [SEQ_W-1:0]              total_a, total_b;
  logic [shrb_pkg::SLOT_A_W-1:0] slot_a;
  logic [shrb_pkg::SLOT_B_W-1:0] slot_b;
  logic [shrb_pkg::POS_A_W-1:0]  pos_a;
  logic [shrb_pkg::POS_B_W-1:0]  pos_b;

  // latched request
  logic              chan;
  logic [SEQ_W-1:0]  start;
  logic [WANT_W-1:0] want;

  // check results
  logic              err;
  logic [DIFF_W-1:0] diff;
  logic [NREC_W-1:0] nrec;
  logic [SEQ_W-1:0]  oldest, newest;

  // stream position
  logic [SEQ_W-1:0]  seq;
  logic [NREC_W-1:0] rec_left;
  logic [POS_W-1:0]  wpos;
  logic [ADDR_W-1:0] addr, addr_next;

  logic [shrb_pkg::WORD_W-1:0] word_sw, rdata_a, rdata_b;
  logic                        is_add, we_a, we_b;
  logic [AAW-1:0]              waddr_a;
  logic [BAW-1:0]              waddr_b;

  assign word_sw = {word_in[7:0], word_in[15:8]};
  assign is_add  = cmd.accept && (command == shrb_pkg::CMD_ADD);
  assign we_a    = is_add && !channel;
  assign we_b    = is_add && channel;
  assign waddr_a = AAW'(slot_a * shrb_pkg::WORDS_A + pos_a);
  assign waddr_b = BAW'(slot_b * shrb_pkg::WORDS_B + pos_b);

  assign status.peek_req = (command == shrb_pkg::CMD_PEEK);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_a <= '0;
      total_b <= '0;
      slot_a  <= '0;
      slot_b  <= '0;
      pos_a   <= '0;
      pos_b   <= '0;
    end else if (cmd.accept) begin
      case (command)
        shrb_pkg::CMD_ADD: begin
          if (!channel) begin
            if (pos_a == shrb_pkg::POS_A_W'(shrb_pkg::WORDS_A - 1)) begin
              pos_a   <= '0;
              slot_a  <= (slot_a == shrb_pkg::SLOT_A_W'(shrb_pkg::RECORDS_A - 1)) ?
                         '0 : slot_a + 1'b1;
              total_a <= total_a + 1'b1;
            end else begin
              pos_a <= pos_a + 1'b1;
            end
          end else begin
            if (pos_b == shrb_pkg::POS_B_W'(shrb_pkg::WORDS_B - 1)) begin
              pos_b   <= '0;
              slot_b  <= (slot_b == shrb_pkg::SLOT_B_W'(shrb_pkg::RECORDS_B - 1)) ?
                         '0 : slot_b + 1'b1;
              total_b <= total_b + 1'b1;
            end else begin
              pos_b <= pos_b + 1'b1;
            end
          end
        end
        shrb_pkg::CMD_RESET: begin
          if (!channel) begin
            total_a <= '0;
            slot_a  <= '0;
            pos_a   <= '0;
          end else begin
            total_b <= '0;
            slot_b  <= '0;
            pos_b   <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      chan  <= channel;
      start <= start_seq;
      want  <= record_count;
    end
  end

  // window check and record clipping
  logic [SEQ_W-1:0]  sel_total, sel_depth, diff32, oldest_c, newest_c;
  logic              in_window;
  logic [WANT_W-1:0] want1, n_clip, n_sat, maxr;

  always_comb begin
    sel_total = chan ? total_b : total_a;
    sel_depth = chan ? SEQ_W'(shrb_pkg::RECORDS_B) : SEQ_W'(shrb_pkg::RECORDS_A);
    diff32    = sel_total - start;
    in_window = (start < sel_total) && (diff32 <= sel_depth);
    want1     = (want == '0) ? WANT_W'(1) : want;
    n_clip    = (diff32 < SEQ_W'(want1)) ? diff32[WANT_W-1:0] : want1;
    maxr      = chan ? WANT_W'(shrb_pkg::MAXR_B) : WANT_W'(shrb_pkg::MAXR_A);
    n_sat     = (n_clip > maxr) ? maxr : n_clip;
    oldest_c  = (sel_total > sel_depth) ? sel_total - sel_depth : '0;
    newest_c  = (sel_total != '0) ? sel_total - 1'b1 : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      err    <= !in_window;
      diff   <= diff32[DIFF_W-1:0];
      nrec   <= n_sat[NREC_W-1:0];
      oldest <= oldest_c;
      newest <= newest_c;
    end
  end

  // first record slot and word address
  logic [IDX_W-1:0]  slot_ext, diff_ext, depth_ext, idx;
  logic [AAW-1:0]    base_a;
  logic [BAW-1:0]    base_b;
  logic [ADDR_W-1:0] base, addr_inc;
  logic [POS_W-1:0]  wpr_last;
  logic              rec_end;

  always_comb begin
    slot_ext  = chan ? IDX_W'(slot_b) : IDX_W'(slot_a);
    diff_ext  = IDX_W'(diff);
    depth_ext = chan ? IDX_W'(shrb_pkg::RECORDS_B) : IDX_W'(shrb_pkg::RECORDS_A);
    idx       = (slot_ext >= diff_ext) ? slot_ext - diff_ext
                                       : slot_ext + depth_ext - diff_ext;
    base_a    = AAW'(idx * shrb_pkg::WORDS_A);
    base_b    = BAW'(idx * shrb_pkg::WORDS_B);
    base      = chan ? ADDR_W'(base_b) : ADDR_W'(base_a);
    if (chan) begin
      addr_inc = (addr == ADDR_W'(shrb_pkg::DEPTH_WORDS_B - 1)) ? '0 : addr + 1'b1;
    end else begin
      addr_inc = (addr == ADDR_W'(shrb_pkg::DEPTH_WORDS_A - 1)) ? '0 : addr + 1'b1;
    end
    wpr_last  = chan ? POS_W'(shrb_pkg::WORDS_B - 1) : POS_W'(shrb_pkg::WORDS_A - 1);
    rec_end   = (wpos == wpr_last);
    if (cmd.setup) begin
      addr_next = base;
    end else if (cmd.advance) begin
      addr_next = addr_inc;
    end else begin
      addr_next = addr;
    end
  end

  assign status.last = err || ((rec_left == NREC_W'(1)) && rec_end);

  always_ff @(posedge clk) begin
    addr <= addr_next;
    if (cmd.setup) begin
      seq      <= start;
      rec_left <= nrec;
      wpos     <= '0;
    end else if (cmd.advance) begin
      if (rec_end) begin
        wpos     <= '0;
        seq      <= seq + 1'b1;
        rec_left <= rec_left - 1'b1;
      end else begin
        wpos <= wpos + 1'b1;
      end
    end
  end

  shrb_ram #(
    .WIDTH (shrb_pkg::WORD_W),
    .DEPTH (shrb_pkg::DEPTH_WORDS_A)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (word_sw),
    .raddr (addr_next[AAW-1:0]),
    .rdata (rdata_a)
  );

  shrb_ram #(
    .WIDTH (shrb_pkg::WORD_W),
    .DEPTH (shrb_pkg::DEPTH_WORDS_B)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (word_sw),
    .raddr (addr_next[BAW-1:0]),
    .rdata (rdata_b)
  );

  assign res_status = err;
  assign seq_number = err ? '0 : seq;
  assign word_out   = err ? '0 : (chan ? rdata_b : rdata_a);
  assign oldest_seq = oldest;
  assign newest_seq = newest;
  assign last       = status.last;

endmodule

`default_nettype wire

@@ hw/rtl/sequenced_history_ring_buffer_top.sv @@
// Channel   Role    Payload
// in_ch     sink    command, channel, word_in, start_seq, record_count
// out_ch    source  status, seq_number, word_out, oldest_seq, newest_seq, last
//
// Add, channel reset and unused commands are accepted in ST_IDLE; they may follow
// back to back. A peek is accepted, passes the window check and address setup
// states, then streams from the channel's RAM read port one stored word per cycle
// while out_ch is ready; a peek outside the window gives a single error result.
// in_ch is not ready while a peek runs; a stall on out_ch holds the word.
// Synchronous reset clears the record counts and write positions at once.
`default_nettype none

module sequenced_history_ring_buffer_top (
  input wire logic   clk,
  input wire logic   rst,
  shrb_in_if.sink    in_ch,
  shrb_out_if.source out_ch
);

  shrb_pkg::dp_cmd_t    cmd;
  shrb_pkg::dp_status_t status;

  shrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  shrb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .command      (in_ch.command),
    .channel      (in_ch.channel),
    .word_in      (in_ch.word_in),
    .start_seq    (in_ch.start_seq),
    .record_count (in_ch.record_count),
    .res_status   (out_ch.status),
    .seq_number   (out_ch.seq_number),
    .word_out     (out_ch.word_out),
    .oldest_seq   (out_ch.oldest_seq),
    .newest_seq   (out_ch.newest_seq),
    .last         (out_ch.last)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_sequenced_history_ring_buffer_top.sv @@
`timescale 1ns / 100ps

module tb_sequenced_history_ring_buffer_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WORD_W      = shrb_pkg::WORD_W;
  localparam int SEQ_W       = shrb_pkg::SEQ_W;
  localparam int WANT_W      = shrb_pkg::WANT_W;

  typedef struct packed {
    shrb_pkg::command_t   command;
    logic                 channel;
    logic [WORD_W-1:0]    word_in;
    logic [SEQ_W-1:0]     start_seq;
    logic [WANT_W-1:0]    record_count;
  } request_t;

  typedef struct packed {
    logic                 status;
    logic [SEQ_W-1:0]     seq_number;
    logic [WORD_W-1:0]    word_out;
    logic [SEQ_W-1:0]     oldest_seq;
    logic [SEQ_W-1:0]     newest_seq;
    logic                 last;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  shrb_in_if  in_ch ();
  shrb_out_if out_ch ();

  sequenced_history_ring_buffer_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  request_t    pending_items[$];
  reply_t      expected_replies[$];
  request_t    on_bus;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 26;
  int unsigned receiver_stall_pct = 26;

  bit [WORD_W-1:0] ring_a [shrb_pkg::DEPTH_WORDS_A];
  bit [WORD_W-1:0] ring_b [shrb_pkg::DEPTH_WORDS_B];
  bit [SEQ_W-1:0]  held_total[2];
  int unsigned     held_slot[2];
  int unsigned     held_pos[2];

  bit [SEQ_W-1:0]  booked_total[2];
  int unsigned     booked_pos[2];

  function automatic int unsigned rec_depth(input logic ch);
    return ch ? shrb_pkg::RECORDS_B : shrb_pkg::RECORDS_A;
  endfunction

  function automatic int unsigned rec_words(input logic ch);
    return ch ? shrb_pkg::WORDS_B : shrb_pkg::WORDS_A;
  endfunction

  function automatic void predict_replies(input request_t rq);
    int unsigned dep, wpr, n, idx, r, w, base;
    bit [SEQ_W-1:0] cnt, avail, s;
    reply_t rp;
    dep = rec_depth(rq.channel);
    wpr = rec_words(rq.channel);
    cnt = held_total[rq.channel];
    case (rq.command)
      shrb_pkg::CMD_ADD: begin
        base = held_slot[rq.channel] * wpr + held_pos[rq.channel];
        if (rq.channel) ring_b[base] = {rq.word_in[7:0], rq.word_in[15:8]};
        else ring_a[base] = {rq.word_in[7:0], rq.word_in[15:8]};
        held_pos[rq.channel]++;
        if (held_pos[rq.channel] == wpr) begin
          held_pos[rq.channel] = 0;
          held_slot[rq.channel] = (held_slot[rq.channel] + 1 == dep) ? 0 :
                                  held_slot[rq.channel] + 1;
          held_total[rq.channel] = cnt + 1;
        end
      end
      shrb_pkg::CMD_PEEK: begin
        rp.oldest_seq = (cnt > dep) ? cnt - dep : '0;
        rp.newest_seq = (cnt != 0) ? cnt - 1 : '0;
        if (!(rq.start_seq < cnt && cnt - rq.start_seq <= dep)) begin
          rp.status     = 1'b1;
          rp.seq_number = '0;
          rp.word_out   = '0;
          rp.last       = 1'b1;
          expected_replies.push_back(rp);
        end else begin
          n = (rq.record_count == 0) ? 1 : rq.record_count;
          avail = cnt - rq.start_seq;
          if (n > avail) n = avail;
          if (n > shrb_pkg::MAX_WORDS / wpr) n = shrb_pkg::MAX_WORDS / wpr;
          for (r = 0; r < n; r++) begin
            s = rq.start_seq + r;
            idx = held_slot[rq.channel] + dep - (cnt - s);
            if (idx >= dep) idx -= dep;
            for (w = 0; w < wpr; w++) begin
              rp.status     = 1'b0;
              rp.seq_number = s;
              rp.word_out   = rq.channel ? ring_b[idx * wpr + w] : ring_a[idx * wpr + w];
              rp.last       = (r + 1 == n) && (w + 1 == wpr);
              expected_replies.push_back(rp);
            end
          end
        end
      end
      shrb_pkg::CMD_RESET: begin
        held_total[rq.channel] = '0;
        held_slot[rq.channel]  = 0;
        held_pos[rq.channel]   = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic void book(input shrb_pkg::command_t cmd, input logic ch,
                               input logic [15:0] word, input logic [31:0] start,
                               input logic [7:0] want);
    request_t rq;
    rq.command      = cmd;
    rq.channel      = ch;
    rq.word_in      = word;
    rq.start_seq    = start;
    rq.record_count = want;
    pending_items.push_back(rq);
    if (cmd == shrb_pkg::CMD_ADD) begin
      booked_pos[ch]++;
      if (booked_pos[ch] == rec_words(ch)) begin
        booked_pos[ch] = 0;
        booked_total[ch]++;
      end
    end else if (cmd == shrb_pkg::CMD_RESET) begin
      booked_pos[ch]   = 0;
      booked_total[ch] = '0;
    end
  endfunction

  function automatic void book_noise(input shrb_pkg::command_t cmd, input logic ch);
    book(cmd, ch, WORD_W'($urandom()), $urandom(), WANT_W'($urandom()));
  endfunction

  function automatic void book_records(input logic ch, input int unsigned nrec);
    repeat (nrec * rec_words(ch)) book_noise(shrb_pkg::CMD_ADD, ch);
  endfunction

  function automatic void book_random_peek(input logic ch);
    bit [SEQ_W-1:0] cnt, oldest, start;
    logic [WANT_W-1:0] want;
    cnt = booked_total[ch];
    oldest = (cnt > rec_depth(ch)) ? cnt - rec_depth(ch) : '0;
    case ($urandom_range(9))
      0: start = $urandom();
      1: start = cnt;
      2: start = oldest - 1;
      default: start = (cnt == 0) ? '0 : oldest + $urandom_range(cnt - oldest - 1);
    endcase
    case ($urandom_range(9))
      0, 1: want = 8'd255;
      2, 3, 4: want = WANT_W'($urandom_range(255));
      default: want = WANT_W'($urandom_range(1, 8));
    endcase
    book(shrb_pkg::CMD_PEEK, ch, WORD_W'($urandom()), start, want);
  endfunction

  function automatic void book_round();
    logic ch;
    int unsigned pick;
    ch = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 40) begin
      book_records(ch, ch ? $urandom_range(1, 4) : 1);
    end else if (pick < 48) begin
      repeat ($urandom_range(1, shrb_pkg::WORDS_A - 1))
        book_noise(shrb_pkg::CMD_ADD, 1'b0);
    end else if (pick < 90) begin
      book_random_peek(ch);
    end else if (pick < 95) begin
      book_noise(shrb_pkg::CMD_RESET, ch);
    end else begin
      book_noise(shrb_pkg::CMD_NONE, ch);
    end
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_replies.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_replies(on_bus);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          on_bus = pending_items.pop_front();
          in_ch.command      <= on_bus.command;
          in_ch.channel      <= on_bus.channel;
          in_ch.word_in      <= on_bus.word_in;
          in_ch.start_seq    <= on_bus.start_seq;
          in_ch.record_count <= on_bus.record_count;
          in_ch.valid        <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    reply_t got, exp;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status     = out_ch.status;
        got.seq_number = out_ch.seq_number;
        got.word_out   = out_ch.word_out;
        got.oldest_seq = out_ch.oldest_seq;
        got.newest_seq = out_ch.newest_seq;
        got.last       = out_ch.last;
        if (expected_replies.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction: st %0d seq %0d word %h old %0d new %0d last %0d",
                   $time, got.status, got.seq_number, got.word_out, got.oldest_seq,
                   got.newest_seq, got.last);
        end else begin
          exp = expected_replies.pop_front();
          if (got.status !== exp.status || got.seq_number !== exp.seq_number ||
              got.word_out !== exp.word_out || got.oldest_seq !== exp.oldest_seq ||
              got.newest_seq !== exp.newest_seq || got.last !== exp.last) begin
            mismatches++;
            $display("%0t: mismatch: expected st %0d seq %0d word %h old %0d new %0d last %0d",
                     $time, exp.status, exp.seq_number, exp.word_out, exp.oldest_seq,
                     exp.newest_seq, exp.last);
            $display("%0t:           actual   st %0d seq %0d word %h old %0d new %0d last %0d",
                     $time, got.status, got.seq_number, got.word_out, got.oldest_seq,
                     got.newest_seq, got.last);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.command      = shrb_pkg::CMD_NONE;
    in_ch.channel      = 1'b0;
    in_ch.word_in      = '0;
    in_ch.start_seq    = '0;
    in_ch.record_count = '0;
    out_ch.ready       = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    book(shrb_pkg::CMD_PEEK, 1'b0, 16'h0000, 32'd0, 8'd1);
    book(shrb_pkg::CMD_PEEK, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 8'd255);
    book(shrb_pkg::CMD_NONE, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 8'd255);
    book(shrb_pkg::CMD_ADD, 1'b1, 16'h0000, 32'd0, 8'd0);
    book(shrb_pkg::CMD_ADD, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 8'd255);
    book(shrb_pkg::CMD_ADD, 1'b1, 16'h12AB, 32'd0, 8'd1);
    book(shrb_pkg::CMD_PEEK, 1'b1, 16'h0000, 32'd0, 8'd0);
    book(shrb_pkg::CMD_PEEK, 1'b1, 16'h0000, 32'd0, 8'd255);
    book(shrb_pkg::CMD_PEEK, 1'b1, 16'h0000, 32'd3, 8'd1);
    book(shrb_pkg::CMD_ADD, 1'b0, 16'hFFFF, 32'd0, 8'd1);
    book(shrb_pkg::CMD_ADD, 1'b0, 16'h0000, 32'd0, 8'd1);
    book(shrb_pkg::CMD_ADD, 1'b0, 16'hA55A, 32'd0, 8'd1);
    book_records(1'b0, 1);
    book(shrb_pkg::CMD_PEEK, 1'b0, 16'h0000, 32'd0, 8'd255);
    book(shrb_pkg::CMD_PEEK, 1'b0, 16'h0000, 32'd1, 8'd1);
    book(shrb_pkg::CMD_RESET, 1'b1, 16'h0000, 32'd0, 8'd0);
    book(shrb_pkg::CMD_PEEK, 1'b1, 16'h0000, 32'd0, 8'd1);
    book(shrb_pkg::CMD_NONE, 1'b1, 16'h0000, 32'd0, 8'd0);

    repeat (4) book_round();

    // hold the sender until every expected transaction has arrived
    drain();

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    book_records(1'b0, 5);
    book(shrb_pkg::CMD_PEEK, 1'b0, 16'h0000, 32'd0, 8'd255);
    book(shrb_pkg::CMD_PEEK, 1'b0, 16'h0000, booked_total[0] - 5, 8'd255);
    book(shrb_pkg::CMD_PEEK, 1'b0, 16'h0000, booked_total[0] - 1, 8'd255);
    drain();

    sender_idle_pct    = 26;
    receiver_stall_pct = 26;
    repeat (4) book_round();
    drain();

    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
